@@ hdl/ldq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldq_pkg: shared types and constants
// Action codes, controller states and the command/status bundles that join
// the deque controller and datapath.
// ----------------------------------------------------------------------------
package ldq_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int DATA_W    = 32;
    localparam int ACT_W     = 2;
    localparam int USER_W    = 3;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_BACK  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_BACK   = 2'd3
    } action_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_WAIT = 1'b1
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;       // take the item: move pointers, write or read a slot
        logic load_direct;  // load the result register from this cycle's decode
        logic load_ram;     // load the result register from the slot read data
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;     // result register is empty or drains this cycle
        logic pop_read;     // offered item is a pop that reads a slot
    } stat_t;

endpackage
`default_nettype wire

@@ hdl/ldq_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldq_ram: generic single-write, single-read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ldq_ram #(
    parameter int WIDTH = ldq_pkg::DATA_W,
    parameter int DEPTH = ldq_pkg::DEPTH_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ hdl/ldq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldq_ctrl: deque controller
// Input handshake and sequencing of slot reads for pops.
// ----------------------------------------------------------------------------
module ldq_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire ldq_pkg::stat_t stat,
    output ldq_pkg::cmd_t       cmd
);

    ldq_pkg::state_t state_reg;
    ldq_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ldq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        s_tready        = 1'b0;
        cmd.accept      = 1'b0;
        cmd.load_direct = 1'b0;
        cmd.load_ram    = 1'b0;
        unique case (state_reg)
            ldq_pkg::ST_IDLE: begin
                s_tready = stat.out_free;
                if (s_tvalid && stat.out_free) begin
                    cmd.accept = 1'b1;
                    if (stat.pop_read) begin
                        state_next = ldq_pkg::ST_WAIT;
                    end else begin
                        cmd.load_direct = 1'b1;
                    end
                end
            end
            ldq_pkg::ST_WAIT: begin
                // slot data is in the read register now
                cmd.load_ram = 1'b1;
                state_next   = ldq_pkg::ST_IDLE;
            end
            default: begin
                state_next = ldq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hdl/ldq_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldq_dp: deque datapath
// Front and back pointers, slot memory and the result register.
// ----------------------------------------------------------------------------
module ldq_dp #(
    parameter int DEPTH = ldq_pkg::DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [ldq_pkg::ACT_W-1:0]     action,
    input  wire logic [ldq_pkg::DATA_W-1:0]    value,
    input  wire ldq_pkg::cmd_t                 cmd,
    output ldq_pkg::stat_t                     stat,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [ldq_pkg::DATA_W-1:0]         m_data,
    output logic [ldq_pkg::USER_W-1:0]         m_user
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_FULL = PW'(DEPTH);
    localparam logic [PW-1:0] PTR_ONE  = PW'(1);

    // pointers hold index plus one, so zero means index -1
    logic [PW-1:0] front_reg, front_next;
    logic [PW-1:0] back_reg, back_next;

    logic                      m_valid_reg, m_valid_next;
    logic [ldq_pkg::DATA_W-1:0] m_data_reg, m_data_next;
    logic                      status_reg, status_next;
    logic                      empty_reg, empty_next;
    logic                      full_reg, full_next;

    ldq_pkg::action_t act;
    logic             ok;
    logic             is_pop;
    logic [PW-1:0]    front_dec;
    logic [PW-1:0]    back_dec;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic [ldq_pkg::DATA_W-1:0] rd_data;

    assign act       = ldq_pkg::action_t'(action);
    assign front_dec = front_reg - PTR_ONE;
    assign back_dec  = back_reg - PTR_ONE;
    assign is_pop    = (act == ldq_pkg::ACT_POP_FRONT) || (act == ldq_pkg::ACT_POP_BACK);

    always_comb begin
        ok      = 1'b0;
        wr_addr = back_reg[AW-1:0];
        rd_addr = front_reg[AW-1:0];
        unique case (act)
            ldq_pkg::ACT_PUSH_FRONT: begin
                ok      = (front_reg != '0);
                wr_addr = front_dec[AW-1:0];
            end
            ldq_pkg::ACT_PUSH_BACK: begin
                ok      = (back_reg != PTR_FULL);
                wr_addr = back_reg[AW-1:0];
            end
            ldq_pkg::ACT_POP_FRONT: begin
                ok      = (front_reg != back_reg);
                rd_addr = front_reg[AW-1:0];
            end
            ldq_pkg::ACT_POP_BACK: begin
                ok      = (front_reg != back_reg);
                rd_addr = back_dec[AW-1:0];
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    assign wr_en = cmd.accept && ok && !is_pop;

    always_comb begin
        front_next = front_reg;
        back_next  = back_reg;
        if (cmd.accept && ok) begin
            unique case (act)
                ldq_pkg::ACT_PUSH_FRONT: front_next = front_dec;
                ldq_pkg::ACT_PUSH_BACK:  back_next  = back_reg + PTR_ONE;
                ldq_pkg::ACT_POP_FRONT:  front_next = front_reg + PTR_ONE;
                ldq_pkg::ACT_POP_BACK:   back_next  = back_dec;
                default:                 front_next = front_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            back_reg  <= '0;
        end else begin
            front_reg <= front_next;
            back_reg  <= back_next;
        end
    end

    ldq_ram #(
        .WIDTH (ldq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // result register
    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        status_next  = status_reg;
        empty_next   = empty_reg;
        full_next    = full_reg;
        if (cmd.load_direct) begin
            m_valid_next = 1'b1;
            m_data_next  = is_pop ? '1 : '0;
            status_next  = !ok;
            empty_next   = (front_next == back_next);
            full_next    = (back_next == PTR_FULL);
        end else if (cmd.load_ram) begin
            m_valid_next = 1'b1;
            m_data_next  = rd_data;
            status_next  = 1'b0;
            empty_next   = (front_next == back_next);
            full_next    = (back_next == PTR_FULL);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
        status_reg <= status_next;
        empty_reg  <= empty_next;
        full_reg   <= full_next;
    end

    assign stat.out_free = !m_valid_reg || m_tready;
    assign stat.pop_read = is_pop && ok;

    assign m_tvalid = m_valid_reg;
    assign m_data   = m_data_reg;
    assign m_user   = {full_reg, empty_reg, status_reg};

endmodule
`default_nettype wire

@@ hdl/linear_array_deque.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_array_deque: double-ended queue in a linear slot array
// Deque of DEPTH signed words in a non-wrapping array with front and back
// pointers; push or pop at either end, one result per item.
// ----------------------------------------------------------------------------
// usage
//   input channel s_*: s_tuser carries the action (push front, push back,
//   pop front, pop back), s_tdata the word to push (ignored for pops)
//   result channel m_*: m_tdata carries the popped word (0 for a push, -1
//   for a refused pop), m_tuser the flags status, empty and full
//   timing: the result of a push or a refused pop shows up the cycle after
//   acceptance, and pushes can follow each other every cycle while the
//   result channel takes them; a pop that reads a slot first does the
//   registered read of the slot memory, then loads the result, and the
//   controller takes no new item until that result is loaded
//   the result register lets a new item in while its result is being taken
//   if m_tready stays low, the result holds and s_tready drops until it
//   is taken; no item is lost or repeated
//   reset (aresetn low, synchronous) empties the queue with both pointers at
//   index -1 and drops any pending result; slot contents are not cleared
//   a refused push or pop leaves the queue unchanged and sets status
// ----------------------------------------------------------------------------
module linear_array_deque #(
    parameter int DEPTH = ldq_pkg::DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input channel
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [ldq_pkg::DATA_W-1:0]    s_tdata,   // [31:0] value
    input  wire logic [ldq_pkg::ACT_W-1:0]     s_tuser,   // [1:0] action
    // result channel
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [ldq_pkg::DATA_W-1:0]         m_tdata,   // [31:0] data
    output logic [ldq_pkg::USER_W-1:0]         m_tuser    // [0] status, [1] empty_res,
                                                          // [2] full_res
);

    // command and status between the controller and datapath
    ldq_pkg::cmd_t  cmd;
    ldq_pkg::stat_t stat;

    // controller: input handshake, waits out the slot read of a pop
    ldq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: pointers, slot memory and result register
    ldq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .action   (s_tuser),
        .value    (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_data   (m_tdata),
        .m_user   (m_tuser)
    );

endmodule
`default_nettype wire
